[hw/rtl/swrl_pkg.sv]
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the sliding-window rate limiter
// Field widths, register indexes, sequencer states and the shared adder's
// request and response types.
// ----------------------------------------------------------------------------
package swrl_pkg;

	// field widths
	localparam int TIME_W   = 48;
	localparam int DELAY_W  = 24;
	localparam int MAXREQ_W = 5;
	localparam int WINDOW_W = 24;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIME_W-1:0]   TIME_MAX      = {TIME_W{1'b1}};
	localparam logic [DELAY_W-1:0]  DELAY_MAX     = {DELAY_W{1'b1}};
	localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 24'd1000;
	localparam logic [MAXREQ_W-1:0] MAXREQ_RESET  = '0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'b1;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_GRANT = 5'b01000,
		ST_FIN   = 5'b10000
	} swrl_state_t;

	// shared adder operation
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} swrl_op_t;

	typedef struct packed {
		swrl_op_t          op;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} swrl_alu_req_t;

	// res[TIME_W] is the carry on add, the borrow sign on subtract
	typedef struct packed {
		logic [TIME_W:0] res;
	} swrl_alu_rsp_t;

endpackage

[hw/rtl/sliding_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter: deferring sliding-window log rate limiter
// Keeps a ring of granted times and returns, per request, the time at which
// the request may run.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_wdata write max_requests (index 0)
//   or window_ms (index 1); write only while busy is low.
//   Request: a transfer happens at a clock edge with start high and busy low;
//   now_ms is captured there. busy stays high until the result is out.
//   Result: done pulses for one cycle with grant_time_ms, was_delayed and
//   delay_ms valid in that cycle; the receiver cannot stall the block.
//   Sequence: with max_requests zero, idle goes straight to the final state.
//   Otherwise the ring head is read, then head entries are dropped (at most
//   RING_DEPTH) until one is kept or the ring is empty, then the grant is
//   appended. The head scan is the limit: one ring read and one window-end
//   add per cycle. The next request can be taken in the cycle done is high.
//   Reset: ring empty, max_requests 0 (limiting off), window_ms 1000.
//   Ring contents are not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter import swrl_pkg::*; #(
	parameter int RING_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// request
	input  logic                 start,
	output logic                 busy,
	input  logic [TIME_W-1:0]    now_ms,
	// result
	output logic                 done,
	output logic [TIME_W-1:0]    grant_time_ms,
	output logic                 was_delayed,
	output logic [DELAY_W-1:0]   delay_ms
);

	localparam int HW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(RING_DEPTH + 1);
	localparam int CMPW = (CW > MAXREQ_W) ? CW : MAXREQ_W;
	localparam int SW   = CW + 1;

	localparam logic [HW-1:0] HEAD_LAST  = HW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(RING_DEPTH);
	localparam logic [SW-1:0] DEPTH_S    = SW'(RING_DEPTH);

	swrl_state_t          state_q;
	logic [MAXREQ_W-1:0]  maxreq_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [HW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic                 done_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    end_q;
	logic [TIME_W-1:0]    grant_q;
	logic [TIME_W-1:0]    grant_out_q;
	logic                 delayed_q;
	logic [DELAY_W-1:0]   delay_q;

	swrl_alu_req_t        alu_req;
	swrl_alu_rsp_t        alu_rsp;
	logic [TIME_W-1:0]    rd_data;
	logic [HW-1:0]        rd_addr;
	logic [HW-1:0]        head_inc;
	logic [CMPW-1:0]      count_ext;
	logic [CMPW-1:0]      maxreq_ext;
	logic [TIME_W-1:0]    scan_end;
	logic                 pop;
	logic [TIME_W-1:0]    grant_next;
	logic [SW-1:0]        tail_sum;
	logic [HW-1:0]        wr_addr;
	logic                 ram_we;

	// shared adder
	swrl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// grant ring
	swrl_ram #(
		.WIDTH (TIME_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (grant_next),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// adder operands: head + window while scanning, grant - now at the end
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = rd_data;
		alu_req.b  = {{(TIME_W - WINDOW_W){1'b0}}, window_q};
		if (state_q == ST_FIN) begin
			alu_req.op = ALU_SUB;
			alu_req.a  = grant_q;
			alu_req.b  = now_q;
		end
	end

	// head scan decision
	assign head_inc   = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
	assign count_ext  = CMPW'(count_q);
	assign maxreq_ext = CMPW'(maxreq_q);
	assign scan_end   = alu_rsp.res[TIME_W] ? TIME_MAX : alu_rsp.res[TIME_W-1:0];
	assign pop        = (count_ext > maxreq_ext) || (now_q > scan_end);

	// read the next head while popping so the scan handles one entry per cycle
	assign rd_addr = (state_q == ST_SCAN && pop) ? head_inc : head_q;

	// grant: window end of the head when the ring stays at the limit
	assign grant_next = (count_ext == maxreq_ext && count_q != '0) ? end_q : now_q;

	// append address; a full ring overwrites its head
	assign tail_sum = SW'(head_q) + SW'(count_q);
	always_comb begin
		if (count_q == COUNT_FULL) begin
			wr_addr = head_q;
		end else if (tail_sum >= DEPTH_S) begin
			wr_addr = HW'(tail_sum - DEPTH_S);
		end else begin
			wr_addr = HW'(tail_sum);
		end
	end

	assign ram_we = (state_q == ST_GRANT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxreq_q <= MAXREQ_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_REQUESTS: maxreq_q <= cfg_wdata[MAXREQ_W-1:0];
				REG_WINDOW_MS:    window_q <= cfg_wdata[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (maxreq_q == '0) ? ST_FIN : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (count_q == '0) ? ST_GRANT : ST_SCAN;
				end
				ST_SCAN: begin
					if (pop) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							state_q <= ST_GRANT;
						end
					end else begin
						state_q <= ST_GRANT;
					end
				end
				ST_GRANT: begin
					if (count_q == COUNT_FULL) begin
						head_q <= head_inc;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			now_q <= now_ms;
			if (maxreq_q == '0) begin
				grant_q <= now_ms;
			end
		end
		if (state_q == ST_SCAN && !pop) begin
			end_q <= scan_end;
		end
		if (state_q == ST_GRANT) begin
			grant_q <= grant_next;
		end
		if (state_q == ST_FIN) begin
			grant_out_q <= grant_q;
			delayed_q   <= !alu_rsp.res[TIME_W] && (alu_rsp.res[TIME_W-1:0] != '0);
			if (alu_rsp.res[TIME_W]) begin
				delay_q <= '0;
			end else if (alu_rsp.res[TIME_W-1:DELAY_W] != '0) begin
				delay_q <= DELAY_MAX;
			end else begin
				delay_q <= alu_rsp.res[DELAY_W-1:0];
			end
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign grant_time_ms = grant_out_q;
	assign was_delayed   = delayed_q;
	assign delay_ms      = delay_q;

endmodule

[hw/rtl/swrl_ram.sv]
// ----------------------------------------------------------------------------
// swrl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swrl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/swrl_alu.sv]
// ----------------------------------------------------------------------------
// swrl_alu: shared 49-bit add/subtract unit
// Used for window-end sums during the scan and for grant minus now at the end.
// ----------------------------------------------------------------------------
module swrl_alu import swrl_pkg::*; (
	input  swrl_alu_req_t req,
	output swrl_alu_rsp_t rsp
);

	logic [TIME_W:0] a_ext;
	logic [TIME_W:0] b_ext;

	assign a_ext = {1'b0, req.a};

	// invert b for subtract, carry-in supplied below
	always_comb begin
		case (req.op)
			ALU_SUB: b_ext = ~{1'b0, req.b};
			default: b_ext = {1'b0, req.b};
		endcase
	end

	assign rsp.res = a_ext + b_ext + {{TIME_W{1'b0}}, (req.op == ALU_SUB)};

endmodule

[hw/rtl/swrl_checker.sv]
// ----------------------------------------------------------------------------
// swrl_checker: port-level checks of the rate limiter
// Watches request and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module swrl_checker import swrl_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               was_delayed,
	input logic [DELAY_W-1:0] delay_ms
);

	// an accepted request makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request transfer");

	// a result comes out only at the end of a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result outside the end of a busy period");

	// no delay reported unless delayed
	a_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		done && !was_delayed |-> delay_ms == '0)
		else $error("nonzero delay on undelayed result");

	// a delayed result carries a nonzero delay
	a_delay_set: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_delayed |-> delay_ms != '0)
		else $error("zero delay on delayed result");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.was_delayed (was_delayed),
	.delay_ms    (delay_ms)
);

[test/tb_sliding_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_limiter: self-checking bench of the rate limiter
// A directed table covers the disabled limiter, the window edge, saturation,
// time running backwards and a lowered limit. Random phases with fresh limits
// and windows follow. Each result is checked against its table values or a
// bench-side copy of the grant log.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_limiter;
	import swrl_pkg::*;

	localparam int RING_DEPTH   = 32;
	localparam int RANDOM_ITEMS = 1600;
	localparam int N_ROWS       = 30;
	localparam int EXP_DEPTH    = 8;

	// one result of the limiter
	typedef struct packed {
		logic [TIME_W-1:0]  grant;
		logic               delayed;
		logic [DELAY_W-1:0] delay;
	} grant_outcome_t;

	// one row of the directed table: a register write or a request
	typedef struct packed {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [TIME_W-1:0]    t;
		logic                 known;
		grant_outcome_t       outcome;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 start;
	logic                 busy;
	logic [TIME_W-1:0]    now_ms;
	logic                 done;
	logic [TIME_W-1:0]    grant_time_ms;
	logic                 was_delayed;
	logic [DELAY_W-1:0]   delay_ms;

	// bench copy of the grant log and limiter settings
	logic [TIME_W-1:0]   granted_log [RING_DEPTH];
	int                  log_head;
	int                  log_count;
	logic [MAXREQ_W-1:0] lim_max_req;
	logic [WINDOW_W-1:0] lim_window;

	// expected results in transfer order
	grant_outcome_t expected_buf [EXP_DEPTH];
	int             exp_wr = 0;
	int             exp_rd = 0;
	grant_outcome_t oldest_grant;
	stim_row_t      directed_rows [N_ROWS];
	int             mismatches = 0;
	bit             idling = 1'b1;

	sliding_window_rate_limiter #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.now_ms       (now_ms),
		.done         (done),
		.grant_time_ms(grant_time_ms),
		.was_delayed  (was_delayed),
		.delay_ms     (delay_ms)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// end of the window opened by a granted time, saturated at the top
	function automatic logic [TIME_W-1:0] window_close(input logic [TIME_W-1:0] opened);
		logic [TIME_W:0] sum;
		sum = {1'b0, opened} + {{(TIME_W - WINDOW_W + 1){1'b0}}, lim_window};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// grant for one request; updates the bench grant log
	function automatic grant_outcome_t compute_grant(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] gt;
		logic [TIME_W-1:0] wend;
		logic [TIME_W-1:0] diff;
		bit                trimming;
		grant_outcome_t    res;
		gt = t;
		if (lim_max_req != '0) begin
			// drop surplus and expired entries from the head
			trimming = 1'b1;
			while (trimming && log_count > 0) begin
				wend = window_close(granted_log[log_head]);
				if (log_count > int'(lim_max_req) || t > wend) begin
					log_head = (log_head + 1) % RING_DEPTH;
					log_count--;
				end else begin
					trimming = 1'b0;
				end
			end
			if (log_count >= int'(lim_max_req) && log_count > 0) begin
				wend = window_close(granted_log[log_head]);
				if (wend > gt)
					gt = wend;
			end
			if (log_count >= RING_DEPTH) begin
				log_head = (log_head + 1) % RING_DEPTH;
				log_count--;
			end
			granted_log[(log_head + log_count) % RING_DEPTH] = gt;
			log_count++;
		end
		diff        = gt - t;
		res.grant   = gt;
		res.delayed = gt > t;
		res.delay   = !res.delayed ? '0 :
			(diff > {{(TIME_W-DELAY_W){1'b0}}, DELAY_MAX}) ? DELAY_MAX : diff[DELAY_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		return '{1'b1, idx, data, '0, 1'b0, '0};
	endfunction

	function automatic stim_row_t req_row(input logic [TIME_W-1:0] t);
		return '{1'b0, '0, '0, t, 1'b0, '0};
	endfunction

	function automatic stim_row_t req_row_known(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] g, input logic d, input logic [DELAY_W-1:0] dly);
		return '{1'b0, '0, '0, t, 1'b1, '{g, d, dly}};
	endfunction

	// register write, only once the limiter has gone quiet
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		start <= 1'b0;
		while (exp_wr != exp_rd || busy)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_MAX_REQUESTS: lim_max_req = data[MAXREQ_W-1:0];
			REG_WINDOW_MS:    lim_window  = data[WINDOW_W-1:0];
			default: ;
		endcase
	endtask

	// one request transfer; the expected grant is queued on acceptance
	task automatic issue_request(input logic [TIME_W-1:0] t, input logic known,
			input grant_outcome_t given);
		grant_outcome_t predicted;
		while (idling && $urandom_range(99) < 35) begin
			start  <= 1'b0;
			cfg_we <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		cfg_we <= 1'b0;
		now_ms <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = compute_grant(t);
		expected_buf[exp_wr % EXP_DEPTH] = known ? given : predicted;
		exp_wr++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (exp_wr == exp_rd) begin
				$error("result with none expected: grant_time_ms=%0h", grant_time_ms);
				mismatches++;
			end else begin
				oldest_grant = expected_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (grant_time_ms !== oldest_grant.grant) begin
					$error("grant_time_ms: expected %0h, got %0h", oldest_grant.grant, grant_time_ms);
					mismatches++;
				end
				if (was_delayed !== oldest_grant.delayed) begin
					$error("was_delayed: expected %0b, got %0b", oldest_grant.delayed, was_delayed);
					mismatches++;
				end
				if (delay_ms !== oldest_grant.delay) begin
					$error("delay_ms: expected %0h, got %0h", oldest_grant.delay, delay_ms);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int                k;
		int                phase_no;
		int                phase_items;
		int                random_sent;
		int                drain_cycles;
		int                pick;
		longint            step_hi;
		logic [TIME_W-1:0] cur_time;
		logic [TIME_W-1:0] t;
		logic [CFG_W-1:0]  junk;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		start     <= 1'b0;
		now_ms    <= '0;
		log_head    = 0;
		log_count   = 0;
		lim_max_req = MAXREQ_RESET;
		lim_window  = WINDOW_RESET;

		directed_rows = '{
			// limiting off after reset: grant is now
			req_row_known(48'd0, 48'd0, 1'b0, 24'd0),
			req_row_known(TIME_MAX, TIME_MAX, 1'b0, 24'd0),
			req_row_known(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0, 24'd0),
			// limit 2 (upper write bits ignored), window 100
			cfg_row(REG_MAX_REQUESTS, 24'hFFFFE2),
			cfg_row(REG_WINDOW_MS, 24'd100),
			req_row_known(48'd1000, 48'd1000, 1'b0, 24'd0),
			req_row_known(48'd1010, 48'd1010, 1'b0, 24'd0),
			req_row_known(48'd1020, 48'd1100, 1'b1, 24'd80),
			req_row(48'd1020),
			// window expired: whole log drops
			req_row(48'd5000),
			// time going backwards
			req_row(48'd0),
			// widest window, limit 1: huge backward step saturates the delay
			cfg_row(REG_WINDOW_MS, 24'hFFFFFF),
			cfg_row(REG_MAX_REQUESTS, 24'd1),
			req_row(48'h0000_1000_0000),
			req_row(48'd0),
			// window end saturates near the top of time
			req_row(TIME_MAX - 48'd10),
			req_row(TIME_MAX - 48'd5),
			// largest limit, empty window
			cfg_row(REG_MAX_REQUESTS, 24'd31),
			cfg_row(REG_WINDOW_MS, 24'd0),
			req_row(TIME_MAX),
			req_row(48'h5555_5555_5555),
			// fill the log, then lower the limit
			cfg_row(REG_WINDOW_MS, 24'd50000),
			req_row(48'd2000),
			req_row(48'd2000),
			req_row(48'd2000),
			req_row(48'd2000),
			cfg_row(REG_MAX_REQUESTS, 24'd1),
			req_row(48'd2001),
			// back to disabled
			cfg_row(REG_MAX_REQUESTS, 24'd0),
			req_row_known(48'd7, 48'd7, 1'b0, 24'd0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < N_ROWS; k++) begin
			if (directed_rows[k].is_write)
				write_register(directed_rows[k].idx, directed_rows[k].data);
			else
				issue_request(directed_rows[k].t, directed_rows[k].known,
					directed_rows[k].outcome);
		end

		// random phases: new settings, then a run of request times
		cur_time    = 48'd100000;
		random_sent = 0;
		phase_no    = 0;
		while (random_sent < RANDOM_ITEMS) begin
			idling = !(phase_no >= 4 && phase_no <= 6);
			junk   = CFG_W'($urandom()) & 24'hFFFFE0;
			pick   = $urandom_range(99);
			if (pick < 10)
				write_register(REG_MAX_REQUESTS, junk);
			else if (pick < 20)
				write_register(REG_MAX_REQUESTS, junk | 24'd31);
			else if (pick < 30)
				write_register(REG_MAX_REQUESTS, junk | 24'd1);
			else if (pick < 80)
				write_register(REG_MAX_REQUESTS, junk | CFG_W'($urandom_range(2, 8)));
			else
				write_register(REG_MAX_REQUESTS, junk | CFG_W'($urandom_range(0, 31)));
			pick = $urandom_range(99);
			if (pick < 5)
				write_register(REG_WINDOW_MS, 24'd0);
			else if (pick < 10)
				write_register(REG_WINDOW_MS, 24'hFFFFFF);
			else if (pick < 15)
				write_register(REG_WINDOW_MS, CFG_W'($urandom()));
			else
				write_register(REG_WINDOW_MS, CFG_W'($urandom_range(1, 2000)));

			pick = $urandom_range(99);
			if (pick < 20)
				cur_time = TIME_W'({$urandom(), $urandom()});
			else if (pick < 30)
				cur_time = TIME_MAX - TIME_W'($urandom_range(0, 5000));

			step_hi     = longint'(lim_window) / (longint'(lim_max_req) + 1) + 2;
			phase_items = $urandom_range(20, 120);
			for (k = 0; k < phase_items; k++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					t = cur_time + TIME_W'($urandom_range(0, 32'(step_hi * 2)));
				else if (pick < 80)
					t = cur_time + TIME_W'(lim_window) + TIME_W'($urandom_range(1, 1000));
				else if (pick < 86)
					t = cur_time - TIME_W'($urandom_range(1, 3000));
				else if (pick < 88)
					t = cur_time - TIME_W'({$urandom_range(1, 255), 24'd0});
				else if (pick < 94)
					t = cur_time;
				else
					t = TIME_W'({$urandom(), $urandom()});
				cur_time = t;
				issue_request(t, 1'b0, '0);
				random_sent++;
			end
			phase_no++;
		end

		// drain, then let the last scan finish
		start        <= 1'b0;
		drain_cycles = 0;
		while (exp_wr != exp_rd && drain_cycles < 2000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (2 * RING_DEPTH) @(posedge clk);
		if (exp_wr != exp_rd) begin
			$error("%0d expected results never arrived", exp_wr - exp_rd);
			mismatches++;
		end
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
